[design/rgb_to_hsv_pixel_assert.svh]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel assertion macros
// Concurrent assertion shorthands clocked on clk, disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

// same-cycle implication
`define RGBHSV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RGBHSV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rgbhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths, constants and types of the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int CH_W        = 8;
	localparam int QUO_W       = 16;
	localparam int HUE_NUM_W   = 20;
	localparam int SAT_NUM_W   = 23;
	localparam int HUE_W       = 15;
	localparam int SAT_W       = 16;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;
	localparam int DIV_BITS    = 2;

	localparam logic [11:0]        HUE_SECTOR     = 12'd3840;
	localparam logic signed [16:0] HUE_FULL       = 17'sd23040;
	localparam logic signed [16:0] HUE_BASE_RED   = 17'sd0;
	localparam logic signed [16:0] HUE_BASE_GREEN = 17'sd7680;
	localparam logic signed [16:0] HUE_BASE_BLUE  = 17'sd15360;
	localparam logic [SAT_W-1:0]   SAT_ONE        = 16'd32768;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [CH_W-1:0] mx;
		sector_t         sector;
		logic            neg;
		logic            grey;
	} side_t;

	typedef struct packed {
		logic [HUE_NUM_W-1:0] hue_num;
		logic [SAT_NUM_W-1:0] sat_num;
		logic [CH_W-1:0]      diff;
		side_t                side;
	} front_t;

endpackage

[design/rgbhsv_front.sv]
// ----------------------------------------------------------------------------
// rgbhsv_front
// Two-stage front end: max, min, sector and signed difference, then the
// dividends and divisors for the hue and saturation dividers.
// ----------------------------------------------------------------------------
module rgbhsv_front (
	input  logic                         clk,
	input  logic                         adv,
	input  logic [rgbhsv_pkg::CH_W-1:0]  red,
	input  logic [rgbhsv_pkg::CH_W-1:0]  green,
	input  logic [rgbhsv_pkg::CH_W-1:0]  blue,
	output rgbhsv_pkg::front_t           front
);
	import rgbhsv_pkg::*;

	logic [CH_W-1:0]   mx;
	logic [CH_W-1:0]   mn;
	sector_t           sector;
	logic signed [8:0] num;

	logic [CH_W-1:0]   mx_s1;
	logic [CH_W-1:0]   diff_s1;
	sector_t           sector_s1;
	logic signed [8:0] num_s1;

	logic [8:0]        num_abs;
	front_t            front_nx;
	front_t            front_s2;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (mx == red) begin
			sector = SEC_RED;
			num    = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (mx == green) begin
			sector = SEC_GREEN;
			num    = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sector = SEC_BLUE;
			num    = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1     <= mx;
			diff_s1   <= mx - mn;
			sector_s1 <= sector;
			num_s1    <= num;
		end
	end

	always_comb begin
		num_abs                = num_s1[8] ? 9'(-num_s1) : 9'(num_s1);
		front_nx.hue_num       = {8'd0, HUE_SECTOR} * {12'd0, num_abs[CH_W-1:0]};
		front_nx.sat_num       = {diff_s1, 15'd0};
		front_nx.diff          = diff_s1;
		front_nx.side.mx       = mx_s1;
		front_nx.side.sector   = sector_s1;
		front_nx.side.neg      = num_s1[8];
		front_nx.side.grey     = (diff_s1 == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			front_s2 <= front_nx;
		end
	end

	assign front = front_s2;

endmodule

[design/rgbhsv_div.sv]
// ----------------------------------------------------------------------------
// rgbhsv_div
// Pipelined restoring divider with an 8-bit divisor. Each stage retires
// BITS quotient bits; the dividend's bits above the quotient must stay
// below the divisor.
// ----------------------------------------------------------------------------
module rgbhsv_div #(
	parameter int NUM_W = rgbhsv_pkg::SAT_NUM_W,
	parameter int BITS  = rgbhsv_pkg::DIV_BITS
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [NUM_W-1:0]              num,
	input  logic [rgbhsv_pkg::CH_W-1:0]   den,
	output logic [rgbhsv_pkg::QUO_W-1:0]  quo,
	output logic                          rem_nz
);
	import rgbhsv_pkg::*;

	localparam int STAGES = QUO_W / BITS;

	logic [CH_W-1:0]  rem_s  [STAGES];
	logic [QUO_W-1:0] work_s [STAGES];
	logic [CH_W-1:0]  den_s  [STAGES];

	genvar k;
	generate
		for (k = 0; k < STAGES; k++) begin : g_stage
			logic [CH_W-1:0]  rem_src;
			logic [QUO_W-1:0] work_src;
			logic [CH_W-1:0]  den_src;
			logic [CH_W-1:0]  rem_nx;
			logic [QUO_W-1:0] work_nx;

			if (k == 0) begin : g_first
				assign rem_src  = CH_W'(num[NUM_W-1:QUO_W]);
				assign work_src = num[QUO_W-1:0];
				assign den_src  = den;
			end else begin : g_next
				assign rem_src  = rem_s[k-1];
				assign work_src = work_s[k-1];
				assign den_src  = den_s[k-1];
			end

			always_comb begin
				logic [CH_W:0]    sh;
				logic [CH_W-1:0]  r;
				logic [QUO_W-1:0] w;
				r  = rem_src;
				w  = work_src;
				sh = '0;
				for (int i = 0; i < BITS; i++) begin
					sh = {r, w[QUO_W-1]};
					w  = {w[QUO_W-2:0], 1'b0};
					if (sh >= {1'b0, den_src}) begin
						sh   = sh - {1'b0, den_src};
						w[0] = 1'b1;
					end
					r = sh[CH_W-1:0];
				end
				rem_nx  = r;
				work_nx = w;
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k]  <= rem_nx;
					work_s[k] <= work_nx;
					den_s[k]  <= den_src;
				end
			end
		end
	endgenerate

	assign quo    = work_s[STAGES-1];
	assign rem_nz = |rem_s[STAGES-1];

endmodule

[design/rgb_to_hsv_pixel.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Streaming RGB to HSV converter, one pixel per clock while m_axis does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one 8-bit RGB pixel per beat, master
//   channel m_axis one HSV result per beat: hue in 1/64 degree (0..23039),
//   saturation in Q1.15 (32768 is one), value as the largest channel.
//   Results leave in input order, one per input beat.
//   An accepted beat passes the front-end stages, the DIV_BITS-dependent
//   divider stages and the output register before its result is on m_axis.
//   Throughput is one beat per cycle unless m_axis stalls; the depth is set
//   by the two 16-bit restoring dividers, retiring DIV_BITS quotient bits a stage.
//   The whole pipeline advances together: while m_axis holds a result that
//   is not taken, s_axis_tready is low and every stage holds its beat.
//   While the output register is empty or being taken, s_axis_tready is
//   high, so beats keep flowing behind a full pipe.
//   arst_n clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel #(
	parameter int DIV_BITS = rgbhsv_pkg::DIV_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// red_in [7:0], green_in [15:8], blue_in [23:16]
	input  logic [rgbhsv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// hue_out [14:0], sat_out [30:15], val_out [38:31], zero [39]
	output logic [rgbhsv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import rgbhsv_pkg::*;

	`include "rgb_to_hsv_pixel_assert.svh"

	localparam int STAGES = QUO_W / DIV_BITS;
	localparam int PIPE   = STAGES + 2;

	logic              adv;
	logic              vld_s  [PIPE];
	side_t             side_s [STAGES];
	logic              out_valid_q;
	logic [HUE_W-1:0]  hue_q;
	logic [SAT_W-1:0]  sat_q;
	logic [CH_W-1:0]   val_q;

	front_t            front;
	logic [QUO_W-1:0]  hue_quo;
	logic              hue_rnz;
	logic [QUO_W-1:0]  sat_quo;
	logic              sat_rnz;

	side_t             side_o;
	logic [16:0]       q_up;
	logic signed [16:0] frac;
	logic signed [16:0] base;
	logic signed [16:0] hue_sum;
	logic [HUE_W-1:0]  hue_nx;
	logic [SAT_W-1:0]  sat_nx;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	rgbhsv_front u_front (
		.clk   (clk),
		.adv   (adv),
		.red   (s_axis_tdata[7:0]),
		.green (s_axis_tdata[15:8]),
		.blue  (s_axis_tdata[23:16]),
		.front (front)
	);

	rgbhsv_div #(
		.NUM_W (HUE_NUM_W),
		.BITS  (DIV_BITS)
	) u_div_hue (
		.clk    (clk),
		.adv    (adv),
		.num    (front.hue_num),
		.den    (front.diff),
		.quo    (hue_quo),
		.rem_nz (hue_rnz)
	);

	rgbhsv_div #(
		.NUM_W (SAT_NUM_W),
		.BITS  (DIV_BITS)
	) u_div_sat (
		.clk    (clk),
		.adv    (adv),
		.num    (front.sat_num),
		.den    (front.side.mx),
		.quo    (sat_quo),
		.rem_nz (sat_rnz)
	);

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE; i++) vld_s[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_axis_tvalid;
			for (int i = 1; i < PIPE; i++) vld_s[i] <= vld_s[i-1];
			out_valid_q <= vld_s[PIPE-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= front.side;
			for (int i = 1; i < STAGES; i++) side_s[i] <= side_s[i-1];
		end
	end

	assign side_o = side_s[STAGES-1];

	always_comb begin
		q_up = {1'b0, hue_quo} + {16'd0, hue_rnz};
		frac = side_o.neg ? -$signed(q_up) : $signed({1'b0, hue_quo});
		case (side_o.sector)
			SEC_RED:   base = HUE_BASE_RED;
			SEC_GREEN: base = HUE_BASE_GREEN;
			SEC_BLUE:  base = HUE_BASE_BLUE;
			default:   base = HUE_BASE_RED;
		endcase
		hue_sum = base + frac;
		if (hue_sum < 0) hue_sum = hue_sum + HUE_FULL;
		hue_nx = side_o.grey ? '0 : hue_sum[HUE_W-1:0];
		sat_nx = side_o.grey ? '0 : sat_quo;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_q <= hue_nx;
			sat_q <= sat_nx;
			val_q <= side_o.mx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, val_q, sat_q, hue_q};

	`RGBHSV_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_s[0], "accepted beat not in first stage")
	`RGBHSV_ASSERT_NOW(a_hue_range, out_valid_q, hue_q < 15'd23040, "hue out of range")
	`RGBHSV_ASSERT_NOW(a_sat_range, out_valid_q, sat_q <= SAT_ONE, "saturation above one")
	`RGBHSV_ASSERT_NOW(a_grey_hue, out_valid_q && (sat_q == '0), hue_q == '0, "grey pixel with hue")
	`RGBHSV_ASSERT_NOW(a_sat_rem, out_valid_q && (sat_q == SAT_ONE), $past(!sat_rnz || !adv), "full saturation with remainder")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: RGB to HSV pixel converter testbench
// Drives pixels into the slave stream and checks each HSV beat on the master
// stream against an in-order queue of table values or fixed-point HSV predictions.
// Primary colors, greys, tied maxima and wrapped hues run first, then random
// pixels with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import rgbhsv_pkg::*;

	localparam int CLK_PERIOD  = 12;
	localparam int RAND_PIXELS = 600;
	localparam int TAIL_CYCLES = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DIR_ROWS    = 22;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] sat;
		logic [CH_W-1:0]  val;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            typed;
		hsv_t            want;
	} pixel_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// red_in [7:0], green_in [15:8], blue_in [23:16]
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// hue_out [14:0], sat_out [30:15], val_out [38:31], zero [39]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	hsv_t hsv_pending [$];
	int   errors = 0;
	int   cycles = 0;
	logic steady = 1'b0;

	pixel_row_t corner_pixels [0:DIR_ROWS-1] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     16'd0,     8'd0}},
		'{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     16'd0,     8'd255}},
		'{8'd1,   8'd1,   8'd1,   1'b1, '{15'd0,     16'd0,     8'd1}},
		'{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     16'd32768, 8'd255}},
		'{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  16'd32768, 8'd255}},
		'{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 16'd32768, 8'd255}},
		'{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  16'd32768, 8'd255}},
		'{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 16'd32768, 8'd255}},
		'{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 16'd32768, 8'd255}},
		'{8'd1,   8'd0,   8'd0,   1'b1, '{15'd0,     16'd32768, 8'd1}},
		'{8'd255, 8'd254, 8'd0,   1'b0, '0},
		'{8'd254, 8'd255, 8'd0,   1'b0, '0},
		'{8'd0,   8'd254, 8'd255, 1'b0, '0},
		'{8'd255, 8'd0,   8'd1,   1'b0, '0},
		'{8'd200, 8'd10,  8'd20,  1'b0, '0},
		'{8'd10,  8'd200, 8'd190, 1'b0, '0},
		'{8'd10,  8'd20,  8'd200, 1'b0, '0},
		'{8'd128, 8'd127, 8'd127, 1'b0, '0},
		'{8'd1,   8'd0,   8'd1,   1'b0, '0},
		'{8'd255, 8'd1,   8'd0,   1'b0, '0},
		'{8'd0,   8'd0,   8'd1,   1'b0, '0},
		'{8'd170, 8'd85,  8'd0,   1'b0, '0}
	};

	rgb_to_hsv_pixel dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic hsv_t hsv_of_pixel(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
			logic [CH_W-1:0] blue);
		int      r, g, b, mx, mn, diff, num, base, frac, hue;
		sector_t sec;
		hsv_t    res;
		r  = int'(red);
		g  = int'(green);
		b  = int'(blue);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		diff = mx - mn;
		res.val = mx[CH_W-1:0];
		if (diff == 0) begin
			res.hue = '0;
			res.sat = '0;
			return res;
		end
		if (mx == r) sec = SEC_RED;
		else if (mx == g) sec = SEC_GREEN;
		else sec = SEC_BLUE;
		case (sec)
			SEC_RED: begin
				num  = g - b;
				base = int'(HUE_BASE_RED);
			end
			SEC_GREEN: begin
				num  = b - r;
				base = int'(HUE_BASE_GREEN);
			end
			default: begin
				num  = r - g;
				base = int'(HUE_BASE_BLUE);
			end
		endcase
		// round the sector fraction toward minus infinity
		if (num >= 0) frac = (int'(HUE_SECTOR) * num) / diff;
		else frac = -((int'(HUE_SECTOR) * -num + diff - 1) / diff);
		hue = base + frac;
		if (hue < 0) hue += int'(HUE_FULL);
		if (hue >= int'(HUE_FULL)) hue -= int'(HUE_FULL);
		res.hue = hue[HUE_W-1:0];
		res.sat = SAT_W'((diff * int'(SAT_ONE)) / mx);
		return res;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
		errors++;
	endtask

	// present one pixel and hold it until the converter takes the beat
	task automatic push_pixel(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
			logic [CH_W-1:0] blue, logic typed, hsv_t want);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {blue, green, red};
		do @(posedge clk); while (!s_axis_tready);
		hsv_pending = {hsv_pending, typed ? want : hsv_of_pixel(red, green, blue)};
	endtask

	task automatic idle_sender();
		if (!steady && $urandom_range(99) < 14) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 14);
	end

	always @(posedge clk) begin
		hsv_t got, want;
		got.hue = m_axis_tdata[14:0];
		got.sat = m_axis_tdata[30:15];
		got.val = m_axis_tdata[38:31];
		if (m_axis_tvalid && m_axis_tready) begin
			if (hsv_pending.size() == 0) begin
				$display("[%0t] unexpected beat: tdata %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = hsv_pending.pop_front();
				if (got.hue !== want.hue) report_mismatch("hue", got.hue, want.hue);
				if (got.sat !== want.sat) report_mismatch("sat", got.sat, want.sat);
				if (got.val !== want.val) report_mismatch("val", got.val, want.val);
				if (m_axis_tdata[39] !== 1'b0) report_mismatch("pad bit", m_axis_tdata[39], 0);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [CH_W-1:0] red, green, blue;
		int              kind;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_pixels[i]) begin
			idle_sender();
			push_pixel(corner_pixels[i].red, corner_pixels[i].green, corner_pixels[i].blue,
				corner_pixels[i].typed, corner_pixels[i].want);
		end

		// drain the pipe before the random pixels
		s_axis_tvalid <= 1'b0;
		while (hsv_pending.size() != 0) @(posedge clk);

		for (int n = 0; n < RAND_PIXELS; n++) begin
			steady <= (n >= 250 && n < 400);
			red   = CH_W'($urandom);
			green = CH_W'($urandom);
			blue  = CH_W'($urandom);
			kind  = $urandom_range(9);
			case (kind)
				0: begin
					green = red;
					blue  = red;
				end
				1: green = red;
				2: blue = green;
				3: blue = red;
				default: ;
			endcase
			idle_sender();
			push_pixel(red, green, blue, 1'b0, '0);
		end
		steady <= 1'b0;
		s_axis_tvalid <= 1'b0;

		while (hsv_pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
